// ===== src/dupr_pkg.sv =====
// Shared types and constants for the duplicate row detector.
package dupr_pkg;

   localparam int WORD_W = 32;
   localparam int RN_W   = 6;
   localparam int CSR_W  = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// ===== src/dupr_ifs.sv =====
// Valid/ready channel interfaces for the word input and the result output.
interface dupr_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [dupr_pkg::WORD_W-1:0] word;
   logic                              starts_set;

   modport source (output valid, word, starts_set, input ready);
   modport sink   (input valid, word, starts_set, output ready);
endinterface

interface dupr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dupr_pkg::RN_W-1:0]   row_number;
   logic [dupr_pkg::RN_W-1:0]   first_index;
   logic                        overflow;

   modport source (output valid, row_number, first_index, overflow, input ready);
   modport sink   (input valid, row_number, first_index, overflow, output ready);
endinterface

// ===== src/dupr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dupr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/duplicate_row_first_index.sv =====
// Duplicate row detector: one item is one word; a result follows the last word of each row.
// Each word of row r (0 < r < MAX_ROWS) passes the sweep over rows 0..r-1, drain and finish
// states; row 0 and overflowed rows go straight to finish. The sweep reads one stored row
// per cycle. A new word is accepted only in idle, after the previous word has finished.
// Reset clears the counters, candidate bits, result valid flag and sets row length to 1.
// The row store is not cleared; no clearing pass is run.
module duplicate_row_first_index #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   dupr_req_if.sink                   req_chan,
   dupr_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic [dupr_pkg::CSR_W-1:0] csr_wdata
);

   import dupr_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int LW    = ($clog2(MAX_COLS + 1) > CSR_W) ? $clog2(MAX_COLS + 1) : CSR_W;
   localparam int DEPTH = MAX_ROWS * (2 ** XW);

   state_type state_ff, state_in;

   logic [CSR_W-1:0]  row_length_ff, row_length_in;
   logic [RCW-1:0]    row_ff, row_in;
   logic [XW-1:0]     col_ff, col_in;
   logic [RCW-1:0]    cur_row_ff, cur_row_in;
   logic [XW-1:0]     cur_col_ff, cur_col_in;
   logic              last_ff, last_in;
   logic              ovf_ff, ovf_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [RW-1:0]     idx_ff, idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [RW-1:0]     rd_idx_ff, rd_idx_in;
   logic [MAX_ROWS-1:0] cand_ff, cand_in;
   logic              found_ff, found_in;
   logic [RW-1:0]     first_ff, first_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RN_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [RN_W-1:0]   rsp_first_ff, rsp_first_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic [LW-1:0]     len_raw, len;
   logic              accept;
   logic [RCW-1:0]    row_eff;
   logic [XW-1:0]     col_raw, col_eff;
   logic              last_eff, ovf_eff;
   logic              rsp_free;
   logic              sweep_last;
   logic              finish_go;
   logic              rd_issue;
   logic              ram_we;
   logic [RW+XW-1:0]  ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_rdata;
   logic              keep;

   dupr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (word_in),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // effective row length, clamped to 1..MAX_COLS
   always_comb begin
      len_raw = LW'(row_length_ff);
      if (len_raw == '0) begin
         len = LW'(1);
      end else if (len_raw > LW'(MAX_COLS)) begin
         len = LW'(MAX_COLS);
      end else begin
         len = len_raw;
      end
   end

   always_comb begin
      row_eff  = req_chan.starts_set ? '0 : row_ff;
      col_raw  = req_chan.starts_set ? '0 : col_ff;
      col_eff  = (LW'(col_raw) >= len) ? XW'(len - LW'(1)) : col_raw;
      last_eff = (LW'(col_eff) + LW'(1)) >= len;
      ovf_eff  = row_eff >= RCW'(MAX_ROWS);
   end

   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign sweep_last = idx_ff == RW'(cur_row_ff - RCW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = (ovf_eff || row_eff == '0) ? ST_FINISH : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!last_ff || rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      rd_issue       = 1'b0;
      finish_go      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_SWEEP: begin
            rd_issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            finish_go = !last_ff || rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign accept    = req_chan.valid && req_chan.ready;
   assign ram_we    = accept && !ovf_eff;
   assign ram_waddr = {RW'(row_eff), col_eff};
   assign ram_raddr = {idx_ff, cur_col_ff};

   // a row stays a candidate while every word so far matches
   assign keep = ((cur_col_ff == '0) || cand_ff[rd_idx_ff]) && (ram_rdata == word_ff);

   always_comb begin
      row_length_in = csr_we ? csr_wdata : row_length_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      last_in       = last_ff;
      ovf_in        = ovf_ff;
      word_in       = req_chan.word;
      idx_in        = idx_ff;
      rd_valid_in   = rd_issue;
      rd_idx_in     = idx_ff;
      cand_in       = cand_ff;
      found_in      = found_ff;
      first_in      = first_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in    = rsp_row_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (accept) begin
         cur_row_in = row_eff;
         cur_col_in = col_eff;
         last_in    = last_eff;
         ovf_in     = ovf_eff;
         idx_in     = '0;
         found_in   = 1'b0;
         first_in   = RW'(row_eff);
      end else begin
         word_in = word_ff;
      end

      if (rd_issue) begin
         idx_in = idx_ff + RW'(1);
      end

      if (rd_valid_ff) begin
         cand_in[rd_idx_ff] = keep;
         if (last_ff && keep && !found_ff) begin
            found_in = 1'b1;
            first_in = rd_idx_ff;
         end
      end

      if (finish_go) begin
         if (last_ff) begin
            col_in       = '0;
            row_in       = ovf_ff ? cur_row_ff : cur_row_ff + RCW'(1);
            rsp_valid_in = 1'b1;
            rsp_row_in   = ovf_ff ? '0 : RN_W'(cur_row_ff);
            rsp_first_in = ovf_ff ? '0 : RN_W'(first_ff);
            rsp_ovf_in   = ovf_ff;
         end else begin
            col_in = cur_col_ff + XW'(1);
            row_in = cur_row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_length_ff <= CSR_W'(1);
         row_ff        <= '0;
         col_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         cand_ff       <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_length_ff <= row_length_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         rd_valid_ff   <= rd_valid_in;
         cand_ff       <= cand_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      last_ff      <= last_in;
      ovf_ff       <= ovf_in;
      word_ff      <= word_in;
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      first_ff     <= first_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_first_ff <= rsp_first_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.row_number  = rsp_row_ff;
   assign rsp_chan.first_index = rsp_first_ff;
   assign rsp_chan.overflow    = rsp_ovf_ff;

endmodule
